/* src/ssvt_pkg.sv */
package ssvt_pkg;

  localparam int NUM_SERVERS  = 8;
  localparam int VERSION_BITS = 32;

  // Width of a cell's position in the chain
  localparam int ID_W    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  // Width for comparing server_index against a cell position or the server count
  localparam int RANGE_W = ((ID_W > 3) ? ID_W : 3) + 1;

  typedef logic [VERSION_BITS-1:0] ver_t;
  localparam ver_t VER_ONES = '1;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_INC = 1'b1
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [2:0]  server_index;
    logic [31:0] new_version;
  } cmd_t;

  typedef struct packed {
    logic        min_recomputed;
    logic [31:0] least_version;
    logic [31:0] upper_bound;
  } res_t;

  // Token passed from cell to cell
  typedef struct packed {
    logic       valid;
    logic       scan_min;  // 0: uniqueness pass, 1: minimum pass
    logic [1:0] cnt;       // entries equal to the minimum, saturating at 2
    logic       hit_eq;    // target entry already holds the new version
    logic       hit_min;   // target entry holds the minimum
    ver_t       m;         // running minimum
  } token_t;

  // Values broadcast from the controller to every cell
  typedef struct packed {
    logic [2:0] idx;
    ver_t       ver;
    ver_t       slowest;
    ver_t       bound;
    logic       plain;
    logic       wr_en;
  } bcast_t;

  function automatic ver_t to_ver(input logic [31:0] x);
    return ver_t'(x);
  endfunction

  function automatic logic [31:0] to_out(input ver_t v);
    return 32'(v);
  endfunction

  // Ordering rule: values above the bound count as older unless plain order applies
  function automatic logic take_min(input ver_t v, input ver_t m, input ver_t b,
                                    input logic plain);
    logic t;
    if (plain) begin
      t = (v < m);
    end else if (m > b) begin
      t = (v > b) && (v < m);
    end else begin
      t = (v > b) || (v < m);
    end
    return t;
  endfunction

endpackage

/* src/slowest_server_version_tracker.sv */
// Channel  | Ports            | Transfer condition
// ---------+------------------+--------------------------------------
// command  | start, busy, cmd | rising edge with start high, busy low
// result   | done, res        | rising edge ending a cycle with done
//
// Flow: a bound increment, or a set to a server index beyond the table,
// answers in the cycle after the command transfer. A set walks a token down the
// chain of NUM_SERVERS cells (one cell a cycle) to test whether the target
// entry holds the unique minimum. When the minimum must be recomputed, a
// second token walks the chain. The chain length sets how long a set takes.
// Reset: synchronous rst sets every entry, the minimum and the bound to all
// ones and leaves the block idle.
// Stalls: the receiver cannot hold off a result; busy holds off commands.
module slowest_server_version_tracker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ssvt_pkg::cmd_t cmd,
  output logic           done,
  output ssvt_pkg::res_t res
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t           state;
  ssvt_pkg::ver_t   slowest;
  ssvt_pkg::ver_t   bound;
  ssvt_pkg::ver_t   cur_ver;
  logic [2:0]       cur_idx;
  logic             plain;
  ssvt_pkg::token_t inj;
  ssvt_pkg::bcast_t bc;
  ssvt_pkg::token_t tail;
  ssvt_pkg::token_t link [ssvt_pkg::NUM_SERVERS+1];
  logic             accept;
  logic             in_range;
  logic             unique_min;
  logic             wr_now;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (ssvt_pkg::RANGE_W'(cmd.server_index)
                     < ssvt_pkg::RANGE_W'(ssvt_pkg::NUM_SERVERS));

  assign tail       = link[ssvt_pkg::NUM_SERVERS];
  assign unique_min = tail.hit_min && (tail.cnt == 2'd1);
  // Write the target entry at the very edge the uniqueness token returns,
  // so that a minimum token injected at that edge already sees the new value
  assign wr_now     = (state == ST_CHECK) && tail.valid && !tail.hit_eq;

  always_comb begin
    bc.idx     = cur_idx;
    bc.ver     = cur_ver;
    bc.slowest = slowest;
    bc.bound   = bound;
    bc.plain   = plain;
    bc.wr_en   = wr_now;
  end

  assign link[0] = inj;

  for (genvar i = 0; i < ssvt_pkg::NUM_SERVERS; i++) begin : g_cell
    ssvt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .id        (ssvt_pkg::ID_W'(i)),
      .bc        (bc),
      .carry_in  (link[i]),
      .carry_out (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slowest   <= ssvt_pkg::VER_ONES;
      bound     <= ssvt_pkg::VER_ONES;
      inj       <= '0;
      done      <= 1'b0;
      plain     <= 1'b0;
      cur_idx   <= '0;
      cur_ver   <= '0;
      res       <= '0;
    end else begin
      // Clear the injected token and the done strobe unless they are set again below
      inj.valid <= 1'b0;
      done      <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_idx <= cmd.server_index;
            cur_ver <= ssvt_pkg::to_ver(cmd.new_version);
            if (cmd.opcode == ssvt_pkg::OP_INC) begin
              // Advance the bound, wrapping
              bound              <= bound + ssvt_pkg::ver_t'(1);
              done               <= 1'b1;
              res.min_recomputed <= 1'b0;
              res.least_version  <= ssvt_pkg::to_out(slowest);
              res.upper_bound    <= ssvt_pkg::to_out(bound + ssvt_pkg::ver_t'(1));
            end else if (!in_range) begin
              done               <= 1'b1;
              res.min_recomputed <= 1'b0;
              res.least_version  <= ssvt_pkg::to_out(slowest);
              res.upper_bound    <= ssvt_pkg::to_out(bound);
            end else begin
              // Launch the uniqueness pass
              inj.valid    <= 1'b1;
              inj.scan_min <= 1'b0;
              inj.cnt      <= 2'd0;
              inj.hit_eq   <= 1'b0;
              inj.hit_min  <= 1'b0;
              inj.m        <= '0;
              state        <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (tail.valid) begin
            if (tail.hit_eq || !unique_min) begin
              done               <= 1'b1;
              res.min_recomputed <= 1'b0;
              res.least_version  <= ssvt_pkg::to_out(slowest);
              res.upper_bound    <= ssvt_pkg::to_out(bound);
              state              <= ST_IDLE;
            end else begin
              // Launch the minimum pass from the new version
              plain        <= (slowest < bound);
              inj.valid    <= 1'b1;
              inj.scan_min <= 1'b1;
              inj.cnt      <= 2'd0;
              inj.hit_eq   <= 1'b0;
              inj.hit_min  <= 1'b0;
              inj.m        <= cur_ver;
              state        <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            slowest            <= tail.m;
            done               <= 1'b1;
            res.min_recomputed <= 1'b1;
            res.least_version  <= ssvt_pkg::to_out(tail.m);
            res.upper_bound    <= ssvt_pkg::to_out(bound);
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A recomputed minimum is reported only at the end of a minimum pass
  a_recompute_from_scan: assert property (@(posedge clk) disable iff (rst)
    done && res.min_recomputed |-> $past(state == ST_SCAN))
    else $error("recomputed result without a minimum pass");

  // A token returns from the chain only while an item is in flight
  a_tail_while_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy)
    else $error("token left the chain while idle");

  // A bound increment answers in the next cycle and keeps the minimum
  a_inc_immediate: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.opcode == ssvt_pkg::OP_INC) |=> done && !res.min_recomputed && !busy)
    else $error("increment not answered at once");

  // The minimum moves only when a minimum pass completes
  a_slowest_stable: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_SCAN && tail.valid) |=> $stable(slowest))
    else $error("minimum changed outside a minimum pass");

endmodule

/* src/ssvt_cell.sv */
module ssvt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ssvt_pkg::ID_W-1:0]  id,
  input  ssvt_pkg::bcast_t           bc,
  input  ssvt_pkg::token_t           carry_in,
  output ssvt_pkg::token_t           carry_out
);

  ssvt_pkg::ver_t   ver;
  ssvt_pkg::token_t carry_next;
  logic             mine;
  logic             eq_slow;

  assign mine    = (ssvt_pkg::RANGE_W'(bc.idx) == ssvt_pkg::RANGE_W'(id));
  assign eq_slow = (ver == bc.slowest);

  always_comb begin
    carry_next = carry_in;
    if (carry_in.valid) begin
      if (!carry_in.scan_min) begin
        if (eq_slow && (carry_in.cnt != 2'd2)) begin
          carry_next.cnt = carry_in.cnt + 2'd1;
        end
        if (mine) begin
          carry_next.hit_eq  = (ver == bc.ver);
          carry_next.hit_min = eq_slow;
        end
      end else if (ssvt_pkg::take_min(ver, carry_in.m, bc.bound, bc.plain)) begin
        carry_next.m = ver;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ver       <= ssvt_pkg::VER_ONES;
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
      if (bc.wr_en && mine) begin
        ver <= bc.ver;
      end
    end
  end

endmodule
